// ===== src/rsdz_pkg.sv =====
// Shared types and constants for the radial stick dead-zone filter.
`default_nettype none
package rsdz_pkg;

  localparam int AXIS_W     = 16;
  localparam int RADIUS_W   = 16;
  localparam int QUOT_W     = 15;
  localparam int FIFO_DEPTH = 32;

  localparam logic [RADIUS_W-1:0] DEAD_ZONE_RESET  = 16'd8000;
  localparam logic [RADIUS_W-1:0] MAX_RADIUS_RESET = 16'd30000;

  localparam logic [0:0] REG_DEAD_ZONE  = 1'b0;
  localparam logic [0:0] REG_MAX_RADIUS = 1'b1;

  typedef struct packed {
    logic signed [AXIS_W-1:0] axis_x;
    logic signed [AXIS_W-1:0] axis_y;
  } sample_t;

  typedef struct packed {
    logic signed [AXIS_W-1:0] out_x;
    logic signed [AXIS_W-1:0] out_y;
    logic                     active;
    logic                     full_scale;
  } result_t;

  // sign and magnitude of both axes, carried alongside the length pipeline
  typedef struct packed {
    logic              sx;
    logic              sy;
    logic [AXIS_W:0]   mx;
    logic [AXIS_W:0]   my;
  } axis_mag_t;

  // classified item handed from front to back
  typedef struct packed {
    axis_mag_t           ax;
    logic [RADIUS_W-1:0] len;
    logic [RADIUS_W-1:0] gain;
    logic [RADIUS_W-1:0] span;
    logic                active;
    logic                full_scale;
    logic                live;
  } mid_t;

endpackage
`default_nettype wire

// ===== src/rsdz_fifo.sv =====
// Small flop-based queue with a combinational read port.
`default_nettype none
module rsdz_fifo import rsdz_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = FIFO_DEPTH
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       wr_en,
  input  wire logic [WIDTH-1:0]           wr_data,
  input  wire logic                       rd_en,
  output logic      [WIDTH-1:0]           rd_data,
  output logic                            empty,
  output logic      [$clog2(DEPTH+1)-1:0] count
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem [0:DEPTH-1];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH-1)) ? '0 : wr_ptr + AW'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH-1)) ? '0 : rd_ptr + AW'(1);
      end
      if (wr_en && !rd_en) begin
        count <= count + CW'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - CW'(1);
      end
    end
  end

  assign rd_data = mem[rd_ptr];
  assign empty   = (count == '0);

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(wr_en && !rd_en && count == CW'(DEPTH)))
    else $error("write into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(rd_en && count == '0))
    else $error("read from empty queue");
`endif

endmodule
`default_nettype wire

// ===== src/rsdz_front.sv =====
// Front end: takes samples, finds the vector length and classifies the item.
`default_nettype none
module rsdz_front import rsdz_pkg::*; #(
  parameter int MID_DEPTH = FIFO_DEPTH
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           push,
  input  wire sample_t                        sample,
  output logic                                full,
  input  wire logic [RADIUS_W-1:0]            dead_zone,
  input  wire logic [RADIUS_W-1:0]            max_radius,
  input  wire logic [$clog2(MID_DEPTH+1)-1:0] mid_count,
  output logic                                mid_wr,
  output mid_t                                mid_item
);
  localparam int CW  = $clog2(MID_DEPTH+1);
  localparam int NSQ = RADIUS_W;   // one root bit per stage

  logic          accept;
  logic [CW-1:0] inflight;
  logic [CW:0]   used;

  assign used   = {1'b0, inflight} + {1'b0, mid_count};
  assign full   = (used >= (CW+1)'(MID_DEPTH));
  assign accept = push && !full;

  // stage 0: magnitudes
  logic               v0;
  axis_mag_t          side0;
  logic signed [AXIS_W:0] xe, ye;
  assign xe = {sample.axis_x[AXIS_W-1], sample.axis_x};
  assign ye = {sample.axis_y[AXIS_W-1], sample.axis_y};

  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else     v0 <= accept;
    side0.sx <= xe[AXIS_W];
    side0.sy <= ye[AXIS_W];
    side0.mx <= xe[AXIS_W] ? (~xe + 1'b1) : xe;
    side0.my <= ye[AXIS_W] ? (~ye + 1'b1) : ye;
  end

  // stage 1: squares
  logic              v1;
  axis_mag_t         side1;
  logic [2*AXIS_W-1:0] sqx_w, sqy_w;
  logic [2*AXIS_W-1:0] sqx, sqy;
  assign sqx_w = (2*AXIS_W)'(side0.mx) * (2*AXIS_W)'(side0.mx);
  assign sqy_w = (2*AXIS_W)'(side0.my) * (2*AXIS_W)'(side0.my);

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else     v1 <= v0;
    side1 <= side0;
    sqx   <= sqx_w;
    sqy   <= sqy_w;
  end

  // square root pipeline: rem holds n - root^2
  logic                sv    [0:NSQ];
  axis_mag_t           sside [0:NSQ];
  logic [2*AXIS_W:0]   srem  [0:NSQ];
  logic [RADIUS_W-1:0] sroot [0:NSQ];

  always_ff @(posedge clk) begin
    if (rst) sv[0] <= 1'b0;
    else     sv[0] <= v1;
    sside[0] <= side1;
    srem[0]  <= (2*AXIS_W+1)'(sqx) + (2*AXIS_W+1)'(sqy);
    sroot[0] <= '0;
  end

  for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
    localparam int B = NSQ - 1 - k;
    logic [2*AXIS_W+1:0] trial;
    logic [2*AXIS_W+1:0] rem_ext;
    assign trial   = ((2*AXIS_W+2)'(sroot[k]) << (B+1)) | ((2*AXIS_W+2)'(1) << (2*B));
    assign rem_ext = (2*AXIS_W+2)'(srem[k]);
    always_ff @(posedge clk) begin
      if (rst) sv[k+1] <= 1'b0;
      else     sv[k+1] <= sv[k];
      sside[k+1] <= sside[k];
      if (rem_ext >= trial) begin
        srem[k+1]  <= srem[k] - trial[2*AXIS_W:0];
        sroot[k+1] <= sroot[k] | (RADIUS_W'(1) << B);
      end else begin
        srem[k+1]  <= srem[k];
        sroot[k+1] <= sroot[k];
      end
    end
  end

  // classify
  logic [RADIUS_W-1:0] len;
  logic                bad, in_dz, act, clamp;
  assign len    = sroot[NSQ];
  assign bad    = (max_radius <= dead_zone);
  assign in_dz  = (len < dead_zone);
  assign act    = !bad && !in_dz;
  assign clamp  = act && (len >= max_radius);

  always_ff @(posedge clk) begin
    if (rst) mid_wr <= 1'b0;
    else     mid_wr <= sv[NSQ];
    mid_item.ax         <= sside[NSQ];
    mid_item.len        <= len;
    mid_item.span       <= max_radius - dead_zone;
    mid_item.gain       <= clamp ? (max_radius - dead_zone) : (len - dead_zone);
    mid_item.active     <= act;
    mid_item.full_scale <= clamp;
    // zero length with zero dead zone is active but would divide by zero, so it is not live
    mid_item.live       <= act && (len != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else if (accept && !mid_wr) begin
      inflight <= inflight + CW'(1);
    end else if (mid_wr && !accept) begin
      inflight <= inflight - CW'(1);
    end
  end

endmodule
`default_nettype wire

// ===== src/rsdz_back.sv =====
// Back end: scales the direction by gain over length times span through a pipelined divider.
`default_nettype none
module rsdz_back import rsdz_pkg::*; #(
  parameter int OUT_DEPTH = FIFO_DEPTH
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           mid_empty,
  input  wire mid_t                           mid_item,
  output logic                                mid_rd,
  input  wire logic [$clog2(OUT_DEPTH+1)-1:0] out_count,
  output logic                                out_wr,
  output result_t                             out_item
);
  localparam int CW  = $clog2(OUT_DEPTH+1);
  localparam int PW  = AXIS_W + 1 + RADIUS_W;   // magnitude times gain
  localparam int NW  = PW + QUOT_W;             // times 32767
  localparam int DW  = 2 * RADIUS_W;            // length times span

  logic [CW-1:0] inflight;
  logic [CW:0]   used;

  assign used   = {1'b0, inflight} + {1'b0, out_count};
  assign mid_rd = !mid_empty && (used < (CW+1)'(OUT_DEPTH));

  typedef struct packed {
    logic sx;
    logic sy;
    logic active;
    logic full_scale;
    logic live;
  } tag_t;

  // b0: products
  logic          v0;
  tag_t          t0;
  logic [PW-1:0] px, py;
  logic [DW-1:0] den0;

  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else     v0 <= mid_rd;
    t0   <= '{mid_item.ax.sx, mid_item.ax.sy, mid_item.active,
              mid_item.full_scale, mid_item.live};
    px   <= PW'(mid_item.ax.mx) * PW'(mid_item.gain);
    py   <= PW'(mid_item.ax.my) * PW'(mid_item.gain);
    den0 <= DW'(mid_item.len) * DW'(mid_item.span);
  end

  // b1: times 32767 as shift and subtract; seeds the divider
  logic          dv   [0:QUOT_W];
  tag_t          dt   [0:QUOT_W];
  logic [DW-1:0] dden [0:QUOT_W];
  logic [NW-1:0] rx   [0:QUOT_W];
  logic [NW-1:0] ry   [0:QUOT_W];
  logic [QUOT_W-1:0] qx [0:QUOT_W];
  logic [QUOT_W-1:0] qy [0:QUOT_W];

  always_ff @(posedge clk) begin
    if (rst) dv[0] <= 1'b0;
    else     dv[0] <= v0;
    dt[0]   <= t0;
    dden[0] <= den0;
    rx[0]   <= {px, {QUOT_W{1'b0}}} - NW'(px);
    ry[0]   <= {py, {QUOT_W{1'b0}}} - NW'(py);
    qx[0]   <= '0;
    qy[0]   <= '0;
  end

  // restoring division, one quotient bit per stage; quotient fits 15 bits
  for (genvar k = 0; k < QUOT_W; k++) begin : g_div
    localparam int B = QUOT_W - 1 - k;
    logic [NW-1:0] sub;
    assign sub = NW'(dden[k]) << B;
    always_ff @(posedge clk) begin
      if (rst) dv[k+1] <= 1'b0;
      else     dv[k+1] <= dv[k];
      dt[k+1]   <= dt[k];
      dden[k+1] <= dden[k];
      if (rx[k] >= sub) begin
        rx[k+1] <= rx[k] - sub;
        qx[k+1] <= qx[k] | (QUOT_W'(1) << B);
      end else begin
        rx[k+1] <= rx[k];
        qx[k+1] <= qx[k];
      end
      if (ry[k] >= sub) begin
        ry[k+1] <= ry[k] - sub;
        qy[k+1] <= qy[k] | (QUOT_W'(1) << B);
      end else begin
        ry[k+1] <= ry[k];
        qy[k+1] <= qy[k];
      end
    end
  end

  logic [AXIS_W-1:0] ux, uy;
  tag_t              tl;
  assign tl = dt[QUOT_W];
  assign ux = tl.live ? {1'b0, qx[QUOT_W]} : '0;
  assign uy = tl.live ? {1'b0, qy[QUOT_W]} : '0;

  assign out_wr              = dv[QUOT_W];
  assign out_item.out_x      = tl.sx ? -ux : ux;
  assign out_item.out_y      = tl.sy ? -uy : uy;
  assign out_item.active     = tl.active;
  assign out_item.full_scale = tl.full_scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else if (mid_rd && !out_wr) begin
      inflight <= inflight + CW'(1);
    end else if (out_wr && !mid_rd) begin
      inflight <= inflight - CW'(1);
    end
  end

`ifndef ASSERT_OFF
  a_full_implies_active: assert property (@(posedge clk) disable iff (rst)
    out_wr && out_item.full_scale |-> out_item.active)
    else $error("full-scale item not active");
  a_credit: assert property (@(posedge clk) disable iff (rst)
    used <= (CW+1)'(OUT_DEPTH))
    else $error("back end overcommitted result queue");
`endif

endmodule
`default_nettype wire

// ===== src/radial_stick_dead_zone_top.sv =====
// Top level of the radial stick dead-zone filter.
//
//  channel   handshake          payload
//  sample    push / full        sample_t  (axis_x, axis_y)
//  result    pop / empty        result_t  (out_x, out_y, active, full_scale)
//  config    wr_en              wr_index, wr_data
//
// One item per cycle sustained while the result side keeps popping. The path from
// accept to result runs through the front (magnitude, square and sum stages, 16
// root-bit stages, one classify stage, then the queue write), the middle queue and
// the back (two seed stages and 15 quotient-bit stages, then the queue write).
// Reset clears the queues and pipelines; radii return to 8000 and 30000.
// full rises only when the front and the middle queue hold MID_DEPTH items;
// a stalled result side fills the result queue and then the middle queue.
`default_nettype none
module radial_stick_dead_zone_top import rsdz_pkg::*; #(
  parameter int MID_DEPTH = FIFO_DEPTH,
  parameter int OUT_DEPTH = FIFO_DEPTH
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire sample_t             sample,
  output logic                     full,
  output logic                     empty,
  input  wire logic                pop,
  output result_t                  result,
  input  wire logic                wr_en,
  input  wire logic [0:0]          wr_index,
  input  wire logic [RADIUS_W-1:0] wr_data
);
  logic [RADIUS_W-1:0] dead_zone, max_radius;

  always_ff @(posedge clk) begin
    if (rst) begin
      dead_zone  <= DEAD_ZONE_RESET;
      max_radius <= MAX_RADIUS_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_DEAD_ZONE:  dead_zone  <= wr_data;
        REG_MAX_RADIUS: max_radius <= wr_data;
        default: ;
      endcase
    end
  end

  logic                           mid_wr, mid_rd, mid_empty;
  mid_t                           mid_in, mid_out;
  logic [$clog2(MID_DEPTH+1)-1:0] mid_count;
  logic                           out_wr;
  result_t                        out_in;
  logic [$clog2(OUT_DEPTH+1)-1:0] out_count;
  logic                           pop_ok;

  rsdz_front #(.MID_DEPTH(MID_DEPTH)) u_front (
    .clk, .rst, .push, .sample, .full,
    .dead_zone, .max_radius, .mid_count,
    .mid_wr, .mid_item(mid_in)
  );

  rsdz_fifo #(.WIDTH($bits(mid_t)), .DEPTH(MID_DEPTH)) u_mid_q (
    .clk, .rst, .wr_en(mid_wr), .wr_data(mid_in), .rd_en(mid_rd),
    .rd_data(mid_out), .empty(mid_empty), .count(mid_count)
  );

  rsdz_back #(.OUT_DEPTH(OUT_DEPTH)) u_back (
    .clk, .rst, .mid_empty, .mid_item(mid_out), .mid_rd,
    .out_count, .out_wr, .out_item(out_in)
  );

  assign pop_ok = pop && !empty;

  rsdz_fifo #(.WIDTH($bits(result_t)), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk, .rst, .wr_en(out_wr), .wr_data(out_in), .rd_en(pop_ok),
    .rd_data(result), .empty, .count(out_count)
  );

`ifndef ASSERT_OFF
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> empty && !full)
    else $error("queues not clear after reset");
`endif

endmodule
`default_nettype wire
